// ----- rtl/core/modular_arithmetic_unit_assert.svh -----
// Assertion macros for the modular arithmetic unit
`ifndef MODULAR_ARITHMETIC_UNIT_ASSERT_SVH
`define MODULAR_ARITHMETIC_UNIT_ASSERT_SVH

// Implication checked on every rising clock edge outside reset
`define MAU_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication checked outside reset
`define MAU_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- rtl/core/mau_pkg.sv -----
// ----------------------------------------------------------------------------
// mau_pkg
// Types and constants shared by the modular arithmetic unit.
// ----------------------------------------------------------------------------
package mau_pkg;

  localparam int unsigned ModBits = 31;
  localparam int unsigned ExpBits = 64;
  localparam int unsigned MWidth  = ModBits + 1;
  localparam int unsigned RedBits = 64;
  localparam int unsigned CntBits = $clog2(RedBits + 1);

  localparam logic [31:0] ModReset = 32'd998244353;
  localparam logic [31:0] TotReset = 32'd998244352;

  typedef enum logic [2:0] {
    OpReduce = 3'd0,
    OpAdd    = 3'd1,
    OpSub    = 3'd2,
    OpNeg    = 3'd3,
    OpMul    = 3'd4,
    OpPow    = 3'd5,
    OpInv    = 3'd6,
    OpDiv    = 3'd7
  } op_e;

  typedef enum logic [0:0] {
    CfgModulus = 1'b0,
    CfgTotient = 1'b1
  } cfg_idx_e;

  typedef enum logic [3:0] {
    StIdle,
    StRedA,
    StRedB,
    StPrep,
    StRedSv,
    StNegFix,
    StPowChk,
    StPowMul,
    StPowSq,
    StMulFin,
    StSimple,
    StOut
  } state_e;

  typedef struct packed {
    logic                start;
    logic [RedBits-1:0]  num;
  } red_req_t;

  typedef struct packed {
    logic               busy;
    logic               done;
    logic [MWidth-1:0]  rem;
  } red_rsp_t;

endpackage

// ----- rtl/core/mau_reducer.sv -----
// ----------------------------------------------------------------------------
// mau_reducer
// Bit-serial restoring remainder: one dividend bit per cycle over a 64-bit dividend.
// ----------------------------------------------------------------------------
module mau_reducer
  import mau_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [MWidth-1:0] mod_i,
  input  red_req_t          req_i,
  output red_rsp_t          rsp_o
);

  logic [RedBits-1:0] num_q, num_d;
  logic [MWidth:0]    rem_q, rem_d;
  logic [CntBits-1:0] cnt_q, cnt_d;
  logic               busy_q, busy_d, done_q, done_d;
  logic [MWidth:0]    shifted;
  logic [MWidth:0]    diff;

  always_comb begin
    shifted = {rem_q[MWidth-1:0], num_q[RedBits-1]};
    diff    = shifted - {1'b0, mod_i};
    num_d   = num_q;
    rem_d   = rem_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    if (req_i.start) begin
      num_d  = req_i.num;
      rem_d  = '0;
      cnt_d  = CntBits'(RedBits);
      busy_d = 1'b1;
    end else if (busy_q) begin
      num_d = {num_q[RedBits-2:0], 1'b0};
      rem_d = diff[MWidth] ? shifted : diff;
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntBits'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
      rem_q  <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.rem  = rem_q[MWidth-1:0];

endmodule

// ----- rtl/core/mau_seq.sv -----
// ----------------------------------------------------------------------------
// mau_seq
// Sequencer: operand reduction, simple ops, square-and-multiply loop.
// ----------------------------------------------------------------------------
module mau_seq
  import mau_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [MWidth-1:0]  mod_i,
  input  logic [31:0]        tot_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [2:0]         op_i,
  input  logic [ModBits-1:0] a_i,
  input  logic [ModBits-1:0] b_i,
  input  logic [ExpBits-1:0] e_i,
  input  logic [63:0]        sv_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [ModBits-1:0] result_o,
  output red_req_t           red_req_o,
  input  red_rsp_t           red_rsp_i
);

  state_e              st_q, st_d;
  op_e                 op_q, op_d;
  logic [MWidth-1:0]   a_q, a_d, b_q, b_d, acc_q, acc_d, sq_q, sq_d, res_q, res_d;
  logic [ExpBits-1:0]  e_q, e_d;
  logic [63:0]         sv_q, sv_d;
  logic                inv2_q, inv2_d;
  logic [MWidth:0]     sum;
  logic [MWidth-1:0]   one_m;

  assign one_m = (mod_i == MWidth'(1)) ? '0 : MWidth'(1);

  always_comb begin
    st_d = st_q; op_d = op_q; a_d = a_q; b_d = b_q; acc_d = acc_q; sq_d = sq_q;
    res_d = res_q; e_d = e_q; sv_d = sv_q; inv2_d = inv2_q;
    red_req_o.start = 1'b0;
    red_req_o.num   = '0;
    sum = '0;
    case (st_q)
      StIdle: begin
        if (in_valid_i) begin
          op_d = op_e'(op_i);
          e_d  = e_i;
          sv_d = sv_i;
          b_d  = {1'b0, b_i};
          inv2_d = 1'b0;
          red_req_o.start = 1'b1;
          red_req_o.num   = {33'd0, a_i};
          st_d = StRedA;
        end
      end
      StRedA: if (red_rsp_i.done) begin
        a_d = red_rsp_i.rem;
        red_req_o.start = 1'b1;
        red_req_o.num   = {33'd0, b_q[ModBits-1:0]};
        st_d = StRedB;
      end
      StRedB: if (red_rsp_i.done) begin
        b_d  = red_rsp_i.rem;
        st_d = StPrep;
      end
      StPrep: begin
        case (op_q)
          OpReduce: begin
            red_req_o.start = 1'b1;
            red_req_o.num   = sv_q[63] ? (64'd0 - sv_q) : sv_q;
            st_d = StRedSv;
          end
          OpMul: begin
            red_req_o.start = 1'b1;
            red_req_o.num   = 64'(a_q) * 64'(b_q);
            st_d = StMulFin;
          end
          OpPow: begin
            acc_d = one_m; sq_d = a_q; st_d = StPowChk;
          end
          OpInv: begin
            acc_d = one_m; sq_d = a_q; e_d = {32'd0, tot_i - 32'd1}; st_d = StPowChk;
          end
          OpDiv: begin
            acc_d = one_m; sq_d = b_q; e_d = {32'd0, tot_i - 32'd1};
            inv2_d = 1'b1; st_d = StPowChk;
          end
          default: st_d = StSimple;
        endcase
      end
      StRedSv: if (red_rsp_i.done) begin
        res_d = red_rsp_i.rem;
        st_d  = (sv_q[63] && red_rsp_i.rem != '0) ? StNegFix : StOut;
      end
      StNegFix: begin
        res_d = mod_i - res_q; st_d = StOut;
      end
      StPowChk: begin
        if (e_q == '0) begin
          if (inv2_q) begin
            red_req_o.start = 1'b1;
            red_req_o.num   = 64'(a_q) * 64'(acc_q);
            st_d = StMulFin;
          end else begin
            res_d = acc_q; st_d = StOut;
          end
        end else if (e_q[0]) begin
          red_req_o.start = 1'b1;
          red_req_o.num   = 64'(acc_q) * 64'(sq_q);
          st_d = StPowMul;
        end else begin
          red_req_o.start = 1'b1;
          red_req_o.num   = 64'(sq_q) * 64'(sq_q);
          st_d = StPowSq;
        end
      end
      StPowMul: if (red_rsp_i.done) begin
        acc_d = red_rsp_i.rem;
        red_req_o.start = 1'b1;
        red_req_o.num   = 64'(sq_q) * 64'(sq_q);
        st_d = StPowSq;
      end
      StPowSq: if (red_rsp_i.done) begin
        sq_d = red_rsp_i.rem;
        e_d  = e_q >> 1;
        st_d = StPowChk;
      end
      StMulFin: if (red_rsp_i.done) begin
        res_d = red_rsp_i.rem; st_d = StOut;
      end
      StSimple: begin
        case (op_q)
          OpAdd: begin
            sum = {1'b0, a_q} + {1'b0, b_q};
            res_d = (sum >= {1'b0, mod_i}) ? MWidth'(sum - {1'b0, mod_i}) : sum[MWidth-1:0];
          end
          OpSub: res_d = (a_q < b_q) ? MWidth'(a_q + mod_i - b_q) : MWidth'(a_q - b_q);
          OpNeg: res_d = (a_q == '0) ? '0 : MWidth'(mod_i - a_q);
          default: res_d = '0;
        endcase
        st_d = StOut;
      end
      StOut: if (out_ready_i) st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
    end else begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d; a_q <= a_d; b_q <= b_d; acc_q <= acc_d; sq_q <= sq_d;
    res_q <= res_d; e_q <= e_d; sv_q <= sv_d; inv2_q <= inv2_d;
  end

  assign in_ready_o  = (st_q == StIdle);
  assign out_valid_o = (st_q == StOut);
  assign result_o    = res_q[ModBits-1:0];

endmodule

// ----- rtl/core/modular_arithmetic_unit.sv -----
// ----------------------------------------------------------------------------
// modular_arithmetic_unit
// Residue arithmetic modulo a configured modulus of up to 2^31.
// ----------------------------------------------------------------------------
// Usage: in_valid_i/in_ready_o take one item (op and operands); the unit
// answers with one item on out_valid_o/out_ready_i. Configuration writes
// (cfg_we_i, cfg_idx_i, cfg_data_i) are to go in while idle; the unit
// does not enforce this. Index 0 modulus, index 1 totient. Reset loads
// 998244353 and 998244352 and empties the unit. One item at a time:
// in_ready_o is low from acceptance until the result is taken. Every
// reduction runs on one shared bit-serial remainder unit. Work per item:
// two operand reductions, plus none for add/sub/neg (done in the
// sequencer), one for reduce/mul, up to 128 for pow (64-bit exponent),
// up to 32 squarings and 32 multiplies for inverse (32-bit totient
// exponent), and for divide one more than inverse. A stalled receiver
// holds the result in place and keeps the input side not ready.
// ----------------------------------------------------------------------------
module modular_arithmetic_unit
  import mau_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [0:0]         cfg_idx_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [2:0]         op_i,
  input  logic [30:0]        operand_a_i,
  input  logic [30:0]        operand_b_i,
  input  logic [63:0]        exponent_i,
  input  logic signed [63:0] signed_value_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [30:0]        result_o
);

  `include "modular_arithmetic_unit_assert.svh"

  logic [31:0]       mod_q, tot_q;
  logic [MWidth-1:0] eff_mod;
  red_req_t          red_req;
  red_rsp_t          red_rsp;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_q <= ModReset;
      tot_q <= TotReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CfgModulus: mod_q <= cfg_data_i;
        CfgTotient: tot_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (mod_q == '0) eff_mod = MWidth'(1);
    else if (mod_q > (32'd1 << ModBits)) eff_mod = MWidth'(33'd1 << ModBits);
    else eff_mod = mod_q[MWidth-1:0];
  end

  mau_reducer u_red (
    .clk_i, .rst_ni, .mod_i(eff_mod), .req_i(red_req), .rsp_o(red_rsp)
  );

  mau_seq u_seq (
    .clk_i, .rst_ni, .mod_i(eff_mod), .tot_i(tot_q),
    .in_valid_i, .in_ready_o, .op_i, .a_i(operand_a_i), .b_i(operand_b_i),
    .e_i(exponent_i), .sv_i(signed_value_i), .out_valid_o, .out_ready_i,
    .result_o, .red_req_o(red_req), .red_rsp_i(red_rsp)
  );

  `MAU_ASSERT_IMPL(a_no_overlap, clk_i, rst_ni, in_ready_o, !out_valid_o)
  `MAU_ASSERT_IMPL(a_res_range, clk_i, rst_ni, out_valid_o, {1'b0, result_o} < eff_mod)
  `MAU_ASSERT_NEXT(a_start_idle, clk_i, rst_ni, red_req.start, red_rsp.busy)

endmodule

// ----- tb/modular_arithmetic_unit_tb.sv -----
// ----------------------------------------------------------------------------
// modular_arithmetic_unit_tb
// Self-checking bench for the modular arithmetic unit: directed corner items,
// then random items under a sweep of modulus/totient settings, with sender
// gaps and receiver stalls; every result is checked against a local model.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module modular_arithmetic_unit_tb;
  import mau_pkg::*;

  localparam int unsigned CycleLimit = 4_000_000;
  localparam logic [63:0] TopMod = 64'h8000_0000;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [0:0]         cfg_idx_i;
  logic [31:0]        cfg_data_i;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [2:0]         op_i;
  logic [30:0]        operand_a_i;
  logic [30:0]        operand_b_i;
  logic [63:0]        exponent_i;
  logic signed [63:0] signed_value_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [30:0]        result_o;

  logic [31:0] modulus_q;
  logic [31:0] totient_q;
  logic [30:0] residue_q[$];
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned cycle_cnt;
  int unsigned fail_cnt;

  modular_arithmetic_unit i_dut (.*);

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  function automatic logic [63:0] ring_modulus();
    logic [63:0] m;
    m = {32'd0, modulus_q};
    if (m == 0) return 64'd1;
    if (m > TopMod) return TopMod;
    return m;
  endfunction

  function automatic logic [63:0] pow_mod(logic [63:0] base, logic [63:0] e, logic [63:0] m);
    logic [63:0] acc;
    logic [63:0] sq;
    acc = 64'd1 % m;
    sq = base % m;
    for (int i = 0; i < ExpBits; i++) begin
      if (e[i]) acc = (acc * sq) % m;
      sq = (sq * sq) % m;
    end
    return acc;
  endfunction

  function automatic logic [63:0] inverse_mod(logic [63:0] a, logic [63:0] m);
    logic [31:0] e;
    e = totient_q - 32'd1;
    return pow_mod(a, {32'd0, e}, m);
  endfunction

  function automatic logic [30:0] predict_residue(op_e op, logic [30:0] ra, logic [30:0] rb,
                                                  logic [63:0] e, logic [63:0] sv);
    logic [63:0] m;
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] r;
    m = ring_modulus();
    a = {33'd0, ra} % m;
    b = {33'd0, rb} % m;
    case (op)
      OpReduce: begin
        if (!sv[63]) r = sv % m;
        else begin
          r = (64'd0 - sv) % m;
          r = (r == 0) ? 64'd0 : m - r;
        end
      end
      OpAdd: begin
        r = a + b;
        if (r >= m) r = r - m;
      end
      OpSub: r = (a < b) ? a + m - b : a - b;
      OpNeg: r = (a == 0) ? 64'd0 : m - a;
      OpMul: r = (a * b) % m;
      OpPow: r = pow_mod(a, e, m);
      OpInv: r = inverse_mod(a, m);
      default: r = (a * inverse_mod(b, m)) % m;
    endcase
    return r[30:0];
  endfunction

  task automatic send_item(op_e op, logic [30:0] a, logic [30:0] b, logic [63:0] e,
                           logic [63:0] sv);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    op_i           <= op;
    operand_a_i    <= a;
    operand_b_i    <= b;
    exponent_i     <= e;
    signed_value_i <= sv;
    do @(posedge clk_i); while (!in_ready_o);
    residue_q.push_back(predict_residue(op, a, b, e, sv));
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (residue_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_config(cfg_idx_e idx, logic [31:0] data);
    wait_idle();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CfgModulus) modulus_q = data;
    else totient_q = data;
  endtask

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99, 0) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (residue_q.size() == 0) begin
        $error("result: unexpected item, actual %0d", result_o);
        fail_cnt++;
      end else begin
        if (result_o !== residue_q[0]) begin
          $error("result: expected %0d actual %0d", residue_q[0], result_o);
          fail_cnt++;
        end
        void'(residue_q.pop_front());
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("** modular_arithmetic_unit: FAILED **");
      $finish;
    end
  end

  task automatic test_directed();
    logic [30:0] hi;
    hi = '1;
    send_item(OpReduce, 0, 0, 0, 64'h8000_0000_0000_0000);
    send_item(OpReduce, 0, 0, 0, 64'h7FFF_FFFF_FFFF_FFFF);
    send_item(OpReduce, 0, 0, 0, '1);
    send_item(OpReduce, 0, 0, 0, -64'sd998244353);
    send_item(OpAdd, 998244352, 998244352, 0, 0);
    send_item(OpAdd, hi, hi, '1, '1);
    send_item(OpSub, 0, 998244352, 0, 0);
    send_item(OpSub, 5, 5, 0, 0);
    send_item(OpNeg, 0, 0, 0, 0);
    send_item(OpNeg, hi, 0, 0, 0);
    send_item(OpMul, 998244352, 998244352, 0, 0);
    send_item(OpMul, hi, hi, 0, 0);
    send_item(OpPow, 0, 0, 0, 0);
    send_item(OpPow, 3, 0, '1, 0);
    send_item(OpPow, hi, 0, 64'h8000_0000_0000_0001, 0);
    send_item(OpInv, 0, 0, 0, 0);
    send_item(OpInv, 3, 0, 0, 0);
    send_item(OpDiv, 10, 3, 0, 0);
    send_item(OpDiv, hi, 0, 0, 0);
  endtask

  task automatic test_random(int unsigned count);
    logic [63:0] m;
    logic [63:0] e;
    logic [63:0] sv;
    logic [30:0] a;
    logic [30:0] b;
    op_e op;
    for (int i = 0; i < count; i++) begin
      case (i % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 62; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 62; end
        default: begin send_idle_pct = 31; recv_stall_pct = 31; end
      endcase
      m = ring_modulus();
      op = op_e'($urandom_range(7, 0));
      a = 31'($urandom());
      b = 31'($urandom());
      if ($urandom_range(3, 0) != 0) begin
        a = 31'({32'd0, $urandom()} % m);
        b = 31'({32'd0, $urandom()} % m);
      end
      sv = {$urandom(), $urandom()};
      if ($urandom_range(1, 0)) sv = {{32{sv[31]}}, sv[31:0]};
      case ($urandom_range(19, 0))
        0: e = {$urandom(), $urandom()};
        1, 2, 3, 4, 5: e = {32'd0, $urandom()};
        default: e = 64'($urandom_range(1000, 0));
      endcase
      send_item(op, a, b, e, sv);
    end
  endtask

  task automatic test_config_sweep();
    logic [31:0] mods[9] = '{32'd1000000007, 32'h8000_0000, 32'hFFFF_FFFF, 32'd0,
                             32'd1, 32'd7, 32'd13, 32'h7FFF_FFFF, 32'd998244353};
    logic [31:0] tots[9] = '{32'd1000000006, 32'h4000_0000, 32'h4000_0000, 32'd1,
                             32'd1, 32'd6, 32'd0, 32'h7FFF_FFFE, 32'd1};
    for (int k = 0; k < 9; k++) begin
      write_config(CfgModulus, mods[k]);
      write_config(CfgTotient, tots[k]);
      test_random(12);
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    op_i = '0;
    operand_a_i = '0;
    operand_b_i = '0;
    exponent_i = '0;
    signed_value_i = '0;
    out_ready_i = 1'b0;
    modulus_q = ModReset;
    totient_q = TotReset;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    cycle_cnt = 0;
    fail_cnt = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(16);
    test_config_sweep();
    wait_idle();
    repeat (200) @(posedge clk_i);
    if (fail_cnt == 0 && residue_q.size() == 0) begin
      $display("** modular_arithmetic_unit: PASSED **");
    end else begin
      $display("** modular_arithmetic_unit: FAILED **");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/mau_pkg.sv
rtl/core/mau_reducer.sv
rtl/core/mau_seq.sv
rtl/core/modular_arithmetic_unit.sv
tb/modular_arithmetic_unit_tb.sv
